// ===== rtl/rprt_pkg.sv =====
// package of codes and constants for the rate paced ring transfer block
package rprt_pkg;

	localparam logic [1:0] ST_STOP    = 2'd0;
	localparam logic [1:0] ST_ACQUIRE = 2'd1;
	localparam logic [1:0] ST_PAUSE   = 2'd2;
	localparam logic [1:0] ST_RUN     = 2'd3;

	localparam logic [1:0] CC_ACQUIRE = 2'd0;
	localparam logic [1:0] CC_PAUSE   = 2'd1;
	localparam logic [1:0] CC_START   = 2'd2;
	localparam logic [1:0] CC_STOP    = 2'd3;

	localparam logic [2:0] K_STATUS = 3'd0;
	localparam logic [2:0] K_CTRL   = 3'd1;
	localparam logic [2:0] K_START  = 3'd2;
	localparam logic [2:0] K_CHUNK  = 3'd3;
	localparam logic [2:0] K_END    = 3'd4;

	localparam logic [1:0] REG_BYTE_RATE = 2'd0;
	localparam logic [1:0] REG_FREQ      = 2'd1;
	localparam logic [1:0] REG_PERIOD    = 2'd2;
	localparam logic [1:0] REG_RING      = 2'd3;

	localparam logic [22:0] BYTE_RATE_RST = 23'd192000;
	localparam logic [31:0] FREQ_RST      = 32'd10000000;
	localparam logic [19:0] PERIOD_RST    = 20'd160000;
	localparam logic [14:0] RING_RST      = 15'd16384;

	localparam logic [14:0] RING_BYTES_MAX = 15'd16384;
	localparam logic [14:0] CHUNK_BYTES    = 15'd500;
	localparam logic [31:0] PERIOD_UNITS   = 32'd10000000;

endpackage

// ===== rtl/rate_paced_ring_transfer.sv =====
// wakeup driven stream state controller with paced ring buffer transfers
//
// input channel (in_valid/in_ready) takes one wakeup per transaction: the
// requested stream state and the ticks elapsed since the last running one.
// output channel (out_valid/out_ready) gives the results one per transaction:
// a control result for a state change or a status result for a refused one,
// then, while running, a data start, chunks of up to 500 bytes round the
// ring, and a data end. last marks the final result of a wakeup. a wakeup
// that asks for the current state outside run gives no result.
// one wakeup at a time: in_ready is high only when the block is idle.
// a running wakeup walks its steps in order: one control step, one multiply
// step, the shared restoring divider (56 quotient bits, one quotient bit per
// cycle), one fix-up step, data start, one step per chunk, one step to leave
// the chunk loop, and data end; the next wakeup is taken in the idle state
// after data end. results sit in an output register; while the receiver
// stalls, a step with a result waits until the output register is free.
// configuration (cfg_we, cfg_index, cfg_data) is to be written by the user
// only while idle; the block does not enforce it. asynchronous reset
// returns the stream to stop with configuration registers at defaults.
module rate_paced_ring_transfer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  requested_state,
	input  logic [31:0] elapsed_ticks,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [1:0]  control_code,
	output logic [14:0] byte_count,
	output logic [13:0] ring_offset,
	output logic        overflow,
	output logic [1:0]  state_now,
	output logic        state_done,
	output logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import rprt_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CTRL  = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_FIX   = 3'd4;
	localparam logic [2:0] S_START = 3'd5;
	localparam logic [2:0] S_CHUNK = 3'd6;
	localparam logic [2:0] S_END   = 3'd7;

	logic [2:0]  state_q;
	logic [22:0] byte_rate_q;
	logic [31:0] freq_q;
	logic [19:0] period_q;
	logic [14:0] ring_q;
	logic [1:0]  run_state_q;
	logic [13:0] off_q;
	logic [33:0] rem_q;
	logic        first_q;
	logic [1:0]  req_q;
	logic [31:0] ticks_q;
	logic [55:0] dq_q;
	logic [31:0] pr_q;
	logic [31:0] divisor_q;
	logic [5:0]  cnt_q;
	logic [14:0] left_q;
	logic        ovf_q;

	logic [31:0] freq_eff;
	logic [14:0] ring_eff;
	logic        moved;
	logic [1:0]  code;
	logic [1:0]  nxt_state;
	logic [54:0] prod;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;
	logic [55:0] due_al;
	logic        ovf_w;
	logic [33:0] rem_add;
	logic [33:0] rem_base;
	logic [14:0] room;
	logic [14:0] chunk_a;
	logic [14:0] chunk_w;
	logic [14:0] off_sum;
	logic [14:0] off_next;
	logic        slot_free;
	logic        emit;
	logic [2:0]  e_kind;
	logic [1:0]  e_code;
	logic [14:0] e_count;
	logic [13:0] e_off;
	logic        e_ovf;
	logic [1:0]  e_state;
	logic        e_done;
	logic        e_last;

	assign freq_eff = (freq_q == 32'd0) ? 32'd1 : freq_q;
	assign ring_eff = (ring_q > RING_BYTES_MAX) ? RING_BYTES_MAX : ring_q;
	assign in_ready = (state_q == S_IDLE);
	assign slot_free = !out_valid || out_ready;

	always_comb begin
		moved = 1'b1;
		code = CC_ACQUIRE;
		nxt_state = run_state_q;
		case ({run_state_q, req_q})
			{ST_STOP, ST_ACQUIRE}: begin
				code = CC_ACQUIRE;
				nxt_state = ST_ACQUIRE;
			end
			{ST_ACQUIRE, ST_PAUSE}: begin
				code = CC_PAUSE;
				nxt_state = ST_PAUSE;
			end
			{ST_PAUSE, ST_RUN}: begin
				code = CC_START;
				nxt_state = ST_RUN;
			end
			{ST_RUN, ST_PAUSE}: begin
				code = CC_PAUSE;
				nxt_state = ST_PAUSE;
			end
			{ST_PAUSE, ST_ACQUIRE}: begin
				code = CC_ACQUIRE;
				nxt_state = ST_ACQUIRE;
			end
			{ST_ACQUIRE, ST_STOP}: begin
				code = CC_STOP;
				nxt_state = ST_STOP;
			end
			default: moved = 1'b0;
		endcase
	end

	// shared multiplier and one bit per cycle divider
	assign prod  = byte_rate_q * (first_q ? {12'd0, period_q} : ticks_q);
	assign trial = {pr_q, dq_q[55]};
	assign diff  = trial - {1'b0, divisor_q};
	assign ge    = trial >= {1'b0, divisor_q};

	assign due_al   = {dq_q[55:2], 2'b00};
	assign ovf_w    = due_al > {41'd0, ring_eff};
	assign rem_add  = (dq_q[0] ? {2'b00, freq_eff} : 34'd0)
		+ (dq_q[1] ? {1'b0, freq_eff, 1'b0} : 34'd0);
	assign rem_base = first_q ? rem_q : {2'b00, pr_q};

	assign room     = ring_eff - {1'b0, off_q};
	assign chunk_a  = (room < left_q) ? room : left_q;
	assign chunk_w  = (chunk_a > CHUNK_BYTES) ? CHUNK_BYTES : chunk_a;
	assign off_sum  = {1'b0, off_q} + chunk_w;
	assign off_next = (off_sum >= ring_eff) ? off_sum - ring_eff : off_sum;

	always_comb begin
		emit = 1'b0;
		e_kind = K_STATUS;
		e_code = CC_ACQUIRE;
		e_count = 15'd0;
		e_off = 14'd0;
		e_ovf = 1'b0;
		e_state = run_state_q;
		e_done = 1'b0;
		e_last = 1'b0;
		case (state_q)
			S_CTRL: begin
				emit = (req_q != run_state_q) && slot_free;
				e_kind = moved ? K_CTRL : K_STATUS;
				e_code = moved ? code : CC_ACQUIRE;
				e_state = nxt_state;
				e_done = 1'b1;
				e_last = (nxt_state != ST_RUN);
			end
			S_START: begin
				emit = slot_free;
				e_kind = K_START;
				e_count = left_q;
				e_ovf = ovf_q;
			end
			S_CHUNK: begin
				emit = slot_free && (left_q != 15'd0);
				e_kind = K_CHUNK;
				e_count = chunk_w;
				e_off = off_q;
				e_ovf = ovf_q;
			end
			S_END: begin
				emit = slot_free;
				e_kind = K_END;
				e_ovf = ovf_q;
				e_last = 1'b1;
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind <= e_kind;
			control_code <= e_code;
			byte_count <= e_count;
			ring_offset <= e_off;
			overflow <= e_ovf;
			state_now <= e_state;
			state_done <= e_done;
			last <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_rate_q <= BYTE_RATE_RST;
			freq_q <= FREQ_RST;
			period_q <= PERIOD_RST;
			ring_q <= RING_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BYTE_RATE: byte_rate_q <= cfg_data[22:0];
				REG_FREQ:      freq_q <= cfg_data;
				REG_PERIOD:    period_q <= cfg_data[19:0];
				REG_RING:      ring_q <= cfg_data[14:0];
				default:       ring_q <= ring_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= requested_state;
			ticks_q <= elapsed_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			run_state_q <= ST_STOP;
			off_q <= 14'd0;
			rem_q <= 34'd0;
			first_q <= 1'b1;
			dq_q <= 56'd0;
			pr_q <= 32'd0;
			divisor_q <= 32'd1;
			cnt_q <= 6'd0;
			left_q <= 15'd0;
			ovf_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CTRL;
					end
				end
				S_CTRL: begin
					if (req_q == run_state_q) begin
						state_q <= (run_state_q == ST_RUN) ? S_MUL : S_IDLE;
					end else if (emit) begin
						run_state_q <= nxt_state;
						if (moved && code == CC_START) begin
							rem_q <= 34'd0;
							first_q <= 1'b1;
						end
						state_q <= (nxt_state == ST_RUN) ? S_MUL : S_IDLE;
					end
				end
				S_MUL: begin
					dq_q <= {1'b0, prod} + (first_q ? 56'd0 : {22'd0, rem_q});
					divisor_q <= first_q ? PERIOD_UNITS : freq_eff;
					pr_q <= 32'd0;
					cnt_q <= 6'd55;
					state_q <= S_DIV;
				end
				S_DIV: begin
					pr_q <= ge ? diff[31:0] : trial[31:0];
					dq_q <= {dq_q[54:0], ge};
					if (cnt_q == 6'd0) begin
						state_q <= S_FIX;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_FIX: begin
					rem_q <= ovf_w ? 34'd0 : rem_base + rem_add;
					left_q <= ovf_w ? ring_eff : due_al[14:0];
					ovf_q <= ovf_w;
					if ({1'b0, off_q} >= ring_eff) begin
						off_q <= 14'd0;
					end
					state_q <= S_START;
				end
				S_START: begin
					if (emit) begin
						state_q <= S_CHUNK;
					end
				end
				S_CHUNK: begin
					if (left_q == 15'd0) begin
						state_q <= S_END;
					end else if (emit) begin
						left_q <= left_q - chunk_w;
						off_q <= off_next[13:0];
					end
				end
				S_END: begin
					if (emit) begin
						first_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_chunk_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHUNK && left_q != 15'd0) |-> (chunk_w != 15'd0))
		else $error("chunk length zero with bytes left");

	a_chunk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == K_CHUNK) |-> (byte_count <= CHUNK_BYTES))
		else $error("chunk longer than chunk size");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transaction taken while busy");

	a_ctrl_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == K_CTRL || kind == K_STATUS)) |-> state_done)
		else $error("control result without state_done");
`endif

endmodule

// ===== sim/rate_paced_ring_transfer_tb.sv =====
// testbench for the rate paced ring transfer block: stream state moves and paced ring chunks
`timescale 1ns / 1ps

module rate_paced_ring_transfer_tb;
	import rprt_pkg::*;

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  code;
		logic [14:0] cnt;
		logic [13:0] off;
		logic        ovf;
		logic [1:0]  st;
		logic        done;
		logic        lst;
	} pkt_t;

	typedef struct {
		logic [1:0]  req;
		logic [31:0] ticks;
		bit          typed;
		logic [2:0]  kind;
		logic [1:0]  code;
		logic [1:0]  st;
	} wake_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  requested_state;
	logic [31:0] elapsed_ticks;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  kind;
	logic [1:0]  control_code;
	logic [14:0] byte_count;
	logic [13:0] ring_offset;
	logic        overflow;
	logic [1:0]  state_now;
	logic        state_done;
	logic        last;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	pkt_t        pending_pkts[$];
	int          err_count;
	int          hold_req;
	int          burst_left;
	int          pushed_last;

	logic [22:0] m_rate;
	logic [31:0] m_freq;
	logic [19:0] m_period;
	logic [14:0] m_ring;
	logic [1:0]  m_state;
	int unsigned m_offset;
	longint unsigned m_rem;
	bit          m_first;

	rate_paced_ring_transfer u_top (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		err_count++;
	endtask

	function automatic pkt_t mk(input logic [2:0] k, input logic [1:0] c, input int unsigned n,
			input int unsigned o, input logic v, input logic d);
		pkt_t p;
		p = '{kind: k, code: c, cnt: n[14:0], off: o[13:0], ovf: v, st: m_state, done: d, lst: 1'b0};
		return p;
	endfunction

	task automatic step_stream(input logic [1:0] req, input logic [31:0] ticks);
		pkt_t p[$];
		longint unsigned freq, ring, due, total;
		logic ovf;
		int unsigned left, chunk;
		logic [1:0] cc;
		bit moved;
		moved = 1;
		cc = CC_ACQUIRE;
		if (req != m_state) begin
			if (m_state == ST_STOP && req == ST_ACQUIRE) begin
				cc = CC_ACQUIRE; m_state = ST_ACQUIRE;
			end else if (m_state == ST_ACQUIRE && req == ST_PAUSE) begin
				cc = CC_PAUSE; m_state = ST_PAUSE;
			end else if (m_state == ST_PAUSE && req == ST_RUN) begin
				cc = CC_START; m_state = ST_RUN; m_rem = 0; m_first = 1;
			end else if (m_state == ST_RUN && req == ST_PAUSE) begin
				cc = CC_PAUSE; m_state = ST_PAUSE;
			end else if (m_state == ST_PAUSE && req == ST_ACQUIRE) begin
				cc = CC_ACQUIRE; m_state = ST_ACQUIRE;
			end else if (m_state == ST_ACQUIRE && req == ST_STOP) begin
				cc = CC_STOP; m_state = ST_STOP;
			end else begin
				moved = 0;
			end
			if (moved) p.push_back(mk(K_CTRL, cc, 0, 0, 0, 1));
			else p.push_back(mk(K_STATUS, CC_ACQUIRE, 0, 0, 0, 1));
		end
		if (m_state == ST_RUN) begin
			freq = (m_freq == 0) ? 1 : m_freq;
			ring = (m_ring > RING_BYTES_MAX) ? RING_BYTES_MAX : m_ring;
			ovf = 0;
			if (m_first) begin
				due = longint'(m_rate) * m_period / PERIOD_UNITS;
			end else begin
				total = longint'(m_rate) * ticks + m_rem;
				due = total / freq;
				m_rem = total % freq;
			end
			m_rem += (due % 4) * freq;
			due -= due % 4;
			if (due > ring) begin
				due = ring; m_rem = 0; ovf = 1;
			end
			if (m_offset >= ring) m_offset = 0;
			p.push_back(mk(K_START, CC_ACQUIRE, due, 0, ovf, 0));
			left = due;
			while (left > 0) begin
				chunk = ring - m_offset;
				if (chunk > left) chunk = left;
				if (chunk > CHUNK_BYTES) chunk = CHUNK_BYTES;
				p.push_back(mk(K_CHUNK, CC_ACQUIRE, chunk, m_offset, ovf, 0));
				left -= chunk;
				m_offset += chunk;
				if (m_offset >= ring) m_offset -= ring;
			end
			p.push_back(mk(K_END, CC_ACQUIRE, 0, 0, ovf, 0));
			m_first = 0;
		end
		if (p.size() > 0) p[p.size() - 1].lst = 1'b1;
		pushed_last = p.size();
		foreach (p[i]) pending_pkts.push_back(p[i]);
	endtask

	// transaction on the input channel, valid left high for the caller
	task automatic send_wakeup(input logic [1:0] req, input logic [31:0] ticks);
		in_valid <= 1'b1;
		requested_state <= req;
		elapsed_ticks <= ticks;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		step_stream(req, ticks);
	endtask

	task automatic pace_sender(input bit no_gaps);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 6);
		gap = no_gaps ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_pkts.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BYTE_RATE: m_rate = val[22:0];
			REG_FREQ:      m_freq = val;
			REG_PERIOD:    m_period = val[19:0];
			REG_RING:      m_ring = val[14:0];
			default: ;
		endcase
	endtask

	function automatic logic [1:0] pick_request();
		if ($urandom_range(0, 99) < 80) begin
			case (m_state)
				ST_STOP:    return ST_ACQUIRE;
				ST_ACQUIRE: return ST_PAUSE;
				ST_PAUSE:   return ST_RUN;
				default:    return ST_RUN;
			endcase
		end
		return 2'($urandom_range(0, 3));
	endfunction

	function automatic logic [31:0] pick_ticks();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'd0;
		if (r < 3) return $urandom;
		return $urandom_range(0, 300000);
	endfunction

	// receiver
	initial begin
		int mode, span, n;
		out_ready <= 1'b0;
		mode = 0;
		span = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 2);
					span = $urandom_range(10, 60);
				end
				span--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		pkt_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pkts.size() == 0) begin
				report("unexpected transaction kind", kind, 0);
			end else begin
				e = pending_pkts.pop_front();
				if (kind !== e.kind) report("kind", kind, e.kind);
				if (control_code !== e.code) report("control_code", control_code, e.code);
				if (byte_count !== e.cnt) report("byte_count", byte_count, e.cnt);
				if (ring_offset !== e.off) report("ring_offset", ring_offset, e.off);
				if (overflow !== e.ovf) report("overflow", overflow, e.ovf);
				if (state_now !== e.st) report("state_now", state_now, e.st);
				if (state_done !== e.done) report("state_done", state_done, e.done);
				if (last !== e.lst) report("last", last, e.lst);
			end
		end
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		wake_row_t rows[$];
		logic [31:0] cfgs[$][4];
		logic [31:0] set[4];
		pkt_t t;
		err_count = 0;
		hold_req = 0;
		burst_left = 0;
		pushed_last = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		requested_state = ST_STOP;
		elapsed_ticks = '0;
		cfg_we = 1'b0;
		cfg_index = REG_BYTE_RATE;
		cfg_data = '0;
		m_rate = BYTE_RATE_RST;
		m_freq = FREQ_RST;
		m_period = PERIOD_RST;
		m_ring = RING_RST;
		m_state = ST_STOP;
		m_offset = 0;
		m_rem = 0;
		m_first = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		rows = '{
			'{ST_ACQUIRE, 32'd0,        1, K_CTRL,   CC_ACQUIRE, ST_ACQUIRE},
			'{ST_ACQUIRE, 32'd5,        0, K_STATUS, CC_ACQUIRE, ST_ACQUIRE},
			'{ST_RUN,     32'd0,        1, K_STATUS, CC_ACQUIRE, ST_ACQUIRE},
			'{ST_PAUSE,   32'd0,        1, K_CTRL,   CC_PAUSE,   ST_PAUSE},
			'{ST_STOP,    32'd0,        1, K_STATUS, CC_ACQUIRE, ST_PAUSE},
			'{ST_RUN,     32'd0,        0, K_STATUS, CC_ACQUIRE, ST_RUN},
			'{ST_RUN,     32'd0,        0, K_STATUS, CC_ACQUIRE, ST_RUN},
			'{ST_RUN,     32'd160000,   0, K_STATUS, CC_ACQUIRE, ST_RUN},
			'{ST_RUN,     32'hFFFFFFFF, 0, K_STATUS, CC_ACQUIRE, ST_RUN},
			'{ST_ACQUIRE, 32'd77777,    0, K_STATUS, CC_ACQUIRE, ST_RUN},
			'{ST_RUN,     32'd1,        0, K_STATUS, CC_ACQUIRE, ST_RUN},
			'{ST_PAUSE,   32'd0,        1, K_CTRL,   CC_PAUSE,   ST_PAUSE},
			'{ST_PAUSE,   32'd9,        0, K_STATUS, CC_ACQUIRE, ST_PAUSE},
			'{ST_RUN,     32'd123456,   0, K_STATUS, CC_ACQUIRE, ST_RUN},
			'{ST_RUN,     32'd123456,   0, K_STATUS, CC_ACQUIRE, ST_RUN},
			'{ST_PAUSE,   32'd0,        1, K_CTRL,   CC_PAUSE,   ST_PAUSE},
			'{ST_ACQUIRE, 32'd0,        1, K_CTRL,   CC_ACQUIRE, ST_ACQUIRE},
			'{ST_STOP,    32'd0,        1, K_CTRL,   CC_STOP,    ST_STOP},
			'{ST_STOP,    32'd0,        0, K_STATUS, CC_ACQUIRE, ST_STOP},
			'{ST_PAUSE,   32'd0,        1, K_STATUS, CC_ACQUIRE, ST_STOP}
		};
		foreach (rows[i]) begin
			send_wakeup(rows[i].req, rows[i].ticks);
			if (rows[i].typed) begin
				repeat (pushed_last) void'(pending_pkts.pop_back());
				t = '{kind: rows[i].kind, code: rows[i].code, cnt: '0, off: '0, ovf: 1'b0,
					st: rows[i].st, done: 1'b1, lst: 1'b1};
				pending_pkts.push_back(t);
			end
			pace_sender(0);
		end
		settle();

		cfgs.push_back('{BYTE_RATE_RST, FREQ_RST, PERIOD_RST, RING_RST});
		cfgs.push_back('{6144000, 1, 1000000, 16384});
		cfgs.push_back('{0, 10000000, 0, 16384});
		cfgs.push_back('{192000, 32'hFFFFFFFF, 160000, 4});
		cfgs.push_back('{192000, 0, 160000, 1000});
		cfgs.push_back('{6144000, 10000000, 1000000, 0});
		cfgs.push_back('{48000, 10000000, 80000, 32767});
		cfgs.push_back('{23'h7FFFFF, 32'hFFFFFFFF, 20'hFFFFF, 16384});
		repeat (2)
			cfgs.push_back('{$urandom_range(0, 6144000), $urandom, $urandom_range(0, 1000000),
				$urandom_range(1, 4096) * 4});

		foreach (cfgs[ph]) begin
			set = cfgs[ph];
			write_reg(REG_BYTE_RATE, set[0]);
			write_reg(REG_FREQ, set[1]);
			write_reg(REG_PERIOD, set[2]);
			write_reg(REG_RING, set[3]);
			if (ph == 0) hold_req = 600;
			for (int k = 0; k < 27; k++) begin
				send_wakeup(pick_request(), pick_ticks());
				pace_sender(ph == 0 && k < 12);
			end
			settle();
		end

		if (err_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
